>>> design/grbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gated rolling baseline detector package
// Field widths, beat layouts, register map and reset values shared by the
// detector and its checker.
// ----------------------------------------------------------------------------
package grbd_pkg;

    // Field widths.
    localparam int SAMPLE_W = 14;
    localparam int DELTA_W  = 15;
    localparam int PCT_W    = 7;
    localparam int FS_W     = 13;

    // Product of a positive sample and one hundred.
    localparam int PNUM_W   = 20;

    // Input beat: sample in the low bits, padded to whole bytes.
    localparam int S_TDATA_W = ((SAMPLE_W + 7) / 8) * 8;

    // Output beat layout, lowest field first.
    localparam int DELTA_LSB = 0;
    localparam int PCT_LSB   = DELTA_LSB + DELTA_W;
    localparam int CFLAG_BIT = PCT_LSB + PCT_W;
    localparam int PFLAG_BIT = CFLAG_BIT + 1;
    localparam int BASE_LSB  = PFLAG_BIT + 1;
    localparam int OUT_BITS  = BASE_LSB + SAMPLE_W;
    localparam int M_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [PCT_W-1:0] PCT_MAX = PCT_W'(100);
    localparam logic [PCT_W-1:0] PCT_MUL = PCT_W'(100);

    // Register map: register index is paddr[3:2].
    localparam int APB_ADDR_W = 4;
    localparam logic [1:0] REG_CONTRACTION = 2'd0;
    localparam logic [1:0] REG_PRESSURE    = 2'd1;
    localparam logic [1:0] REG_FULL_SCALE  = 2'd2;

    // Reset values.
    localparam logic signed [SAMPLE_W-1:0] CONTRACTION_RESET = SAMPLE_W'(1000);
    localparam logic signed [SAMPLE_W-1:0] PRESSURE_RESET    = SAMPLE_W'(500);
    localparam logic [FS_W-1:0]            FULL_SCALE_RESET  = FS_W'(3300);
    localparam logic signed [SAMPLE_W-1:0] BASELINE_RESET    = SAMPLE_W'(400);

endpackage

>>> design/gated_rolling_baseline_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gated rolling baseline detector
// Per-channel moving-average baseline, frozen while the pressure flag is set,
// with threshold flags and a clamped percent of full scale.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats arrive on s_t*: s_tuser selects the channel, s_tdata holds the
//   signed millivolt sample. Each input beat yields exactly one output beat on
//   m_t*: m_tuser echoes the channel, m_tdata carries delta, percent, the two
//   flags and the updated baseline. The user must write thresholds and full scale
//   through the APB port only while the block is idle; the block does not enforce it.
//   One item is in work at a time. An item passes from accept through the read,
//   divider and done states before the next accept. The running sum is
//   SUM_W = 14 + clog2(WINDOW_LEN) bits wide; the baseline mean is formed from
//   it by a restoring divider that retires one quotient bit per cycle, after
//   the window update in the read state. The percent division forms its
//   seven quotient bits alongside it on a second small unit. The output beat
//   is loaded into the output register in the done state.
//   The result sits in an output register, so a new input beat is taken while
//   the previous result still waits; a stalled receiver holds the block only
//   when the next result is ready to be loaded.
//   Reset clears thresholds to their defaults, baselines to 400 mV, and the
//   window positions and sums to zero; the window memory itself is not cleared.
// ----------------------------------------------------------------------------
module gated_rolling_baseline_detector #(
    parameter int WINDOW_LEN    = 32,
    parameter int CHANNEL_COUNT = 2
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [grbd_pkg::S_TDATA_W-1:0]    s_tdata,  // [13:0] sample_mv
    input  logic                              s_tuser,  // [0] channel
    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [14:0] delta_mv, [21:15] pressure_percent, [22] contraction_flag,
    // [23] pressure_flag, [37:24] baseline_mv, rest zero
    output logic [grbd_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tuser,  // [0] channel_out
    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [grbd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import grbd_pkg::*;

    localparam int PW     = $clog2(WINDOW_LEN);
    localparam int CH_W   = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int SUM_W  = SAMPLE_W + PW;
    localparam int CW     = $clog2(WINDOW_LEN + 1);
    localparam int STEP_W = $clog2(SUM_W);
    localparam int PDIV_W = FS_W + PCT_W - 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic signed [SAMPLE_W-1:0] cthr_reg;
    logic signed [SAMPLE_W-1:0] pthr_reg;
    logic [FS_W-1:0]            fs_reg;

    // Per-channel state.
    logic [PW-1:0]              pos_reg  [CHANNEL_COUNT];
    logic                       wrap_reg [CHANNEL_COUNT];
    logic signed [SUM_W-1:0]    sum_reg  [CHANNEL_COUNT];
    logic signed [SAMPLE_W-1:0] base_reg [CHANNEL_COUNT];

    // Window memory, one row per channel.
    logic signed [SAMPLE_W-1:0] win_mem [CHANNEL_COUNT][WINDOW_LEN];
    logic signed [SAMPLE_W-1:0] rd_data_reg;

    // Item in work.
    logic [CH_W-1:0]            ch_reg;
    logic                       chan_bit_reg;
    logic signed [SAMPLE_W-1:0] samp_reg;
    logic signed [DELTA_W-1:0]  delta_reg;
    logic                       cflag_reg;
    logic                       pflag_reg;
    logic                       pct_zero_reg;
    logic                       pct_full_reg;

    // Baseline divider.
    logic [SUM_W-1:0]           quo_reg;
    logic [CW-1:0]              rem_reg;
    logic [CW-1:0]              cnt_reg;
    logic                       neg_reg;
    logic [STEP_W-1:0]          step_reg;

    // Percent divider.
    logic [PNUM_W-1:0]          pnum_reg;
    logic [PDIV_W-1:0]          pdiv_reg;
    logic [PCT_W-1:0]           pq_reg;

    // Output register.
    logic                       m_tvalid_reg;
    logic                       m_tuser_reg;
    logic [OUT_BITS-1:0]        out_data_reg;

    // Handshakes.
    logic s_acc;
    logic cfg_wr;
    logic out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid & s_tready;
    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite & pready;
    assign out_free = ~m_tvalid_reg | m_tready;

    // Fields of the incoming beat.
    logic [CH_W-1:0]            ch_in;
    logic signed [SAMPLE_W-1:0] samp_in;
    logic [FS_W-1:0]            fs_eff;

    assign ch_in   = (CHANNEL_COUNT > 1) ? CH_W'(s_tuser) : '0;
    assign samp_in = signed'(s_tdata[SAMPLE_W-1:0]);
    assign fs_eff  = (fs_reg == '0) ? FS_W'(1) : fs_reg;

    // Window update, evaluated in the read state.
    logic signed [SUM_W-1:0] sum_next;
    logic [PW-1:0]           pos_next;
    logic                    wrap_next;
    logic [CW-1:0]           cnt_next;
    logic [SUM_W-1:0]        mag_next;

    always_comb begin
        sum_next = sum_reg[ch_reg]
                 - (wrap_reg[ch_reg] ? SUM_W'(rd_data_reg) : SUM_W'(0))
                 + SUM_W'(samp_reg);
        pos_next = (pos_reg[ch_reg] == PW'(WINDOW_LEN - 1)) ? '0
                                                            : pos_reg[ch_reg] + 1'b1;
        wrap_next = wrap_reg[ch_reg] | (pos_next == '0);
        cnt_next  = wrap_next ? CW'(WINDOW_LEN) : CW'(pos_next);
        mag_next  = sum_next[SUM_W-1] ? unsigned'(-sum_next) : unsigned'(sum_next);
    end

    // One restoring step of each divider.
    logic [CW:0]         trial;
    logic                q_bit;
    logic [CW-1:0]       rem_next;
    logic                p_bit;
    logic [SUM_W-1:0]    base_mag;
    logic [SAMPLE_W-1:0] base_q;
    logic [SAMPLE_W-1:0] base_next;
    logic [PCT_W-1:0]    pct_next;

    always_comb begin
        trial    = {rem_reg, quo_reg[SUM_W-1]};
        q_bit    = (trial >= {1'b0, cnt_reg});
        rem_next = q_bit ? CW'(trial - {1'b0, cnt_reg}) : trial[CW-1:0];
        p_bit    = (pnum_reg >= PNUM_W'(pdiv_reg));
        base_mag = neg_reg ? -quo_reg : quo_reg;
        base_q   = base_mag[SAMPLE_W-1:0];
        base_next = pflag_reg ? base_reg[ch_reg] : base_q;
        if (pct_zero_reg) begin
            pct_next = '0;
        end else if (pct_full_reg) begin
            pct_next = PCT_MAX;
        end else begin
            pct_next = pq_reg;
        end
    end

    // Window memory: read at accept, written back in the read state.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_READ && !pflag_reg) begin
            win_mem[ch_reg][pos_reg[ch_reg]] <= samp_reg;
        end
        if (s_acc) begin
            rd_data_reg <= win_mem[ch_in][pos_reg[ch_in]];
        end
    end

    // Sequencer, per-channel state, dividers and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            cthr_reg     <= CONTRACTION_RESET;
            pthr_reg     <= PRESSURE_RESET;
            fs_reg       <= FULL_SCALE_RESET;
            for (int c = 0; c < CHANNEL_COUNT; c++) begin
                pos_reg[c]  <= '0;
                wrap_reg[c] <= 1'b0;
                sum_reg[c]  <= '0;
                base_reg[c] <= BASELINE_RESET;
            end
        end else begin
            // Configuration writes.
            if (cfg_wr) begin
                unique case (paddr[APB_ADDR_W-1:2])
                    REG_CONTRACTION: cthr_reg <= signed'(pwdata[SAMPLE_W-1:0]);
                    REG_PRESSURE:    pthr_reg <= signed'(pwdata[SAMPLE_W-1:0]);
                    REG_FULL_SCALE:  fs_reg   <= pwdata[FS_W-1:0];
                    default: ;
                endcase
            end

            // The result beat is loaded in the done state and cleared once
            // the receiver takes it.
            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        ch_reg       <= ch_in;
                        chan_bit_reg <= s_tuser;
                        samp_reg     <= samp_in;
                        delta_reg    <= DELTA_W'(samp_in) - DELTA_W'(base_reg[ch_in]);
                        cflag_reg    <= (samp_in >= cthr_reg);
                        pflag_reg    <= (samp_in >= pthr_reg);
                        pct_zero_reg <= (samp_in <= 0);
                        pct_full_reg <= (samp_in >= signed'({1'b0, fs_eff}));
                        state_reg    <= ST_READ;
                    end
                end
                ST_READ: begin
                    if (!pflag_reg) begin
                        pos_reg[ch_reg]  <= pos_next;
                        wrap_reg[ch_reg] <= wrap_next;
                        sum_reg[ch_reg]  <= sum_next;
                    end
                    neg_reg   <= sum_next[SUM_W-1];
                    quo_reg   <= mag_next;
                    rem_reg   <= '0;
                    cnt_reg   <= cnt_next;
                    pnum_reg  <= PNUM_W'(unsigned'(samp_reg[SAMPLE_W-2:0]) * PCT_MUL);
                    pdiv_reg  <= {fs_eff, {(PCT_W-1){1'b0}}};
                    pq_reg    <= '0;
                    step_reg  <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    rem_reg <= rem_next;
                    quo_reg <= {quo_reg[SUM_W-2:0], q_bit};
                    // Percent quotient needs only its seven bits.
                    if (step_reg < STEP_W'(PCT_W)) begin
                        if (p_bit) begin
                            pnum_reg <= pnum_reg - PNUM_W'(pdiv_reg);
                        end
                        pdiv_reg <= pdiv_reg >> 1;
                        pq_reg   <= {pq_reg[PCT_W-2:0], p_bit};
                    end
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(SUM_W - 1)) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        base_reg[ch_reg] <= base_next;
                        m_tuser_reg      <= chan_bit_reg;
                        out_data_reg     <= {base_next, pflag_reg, cflag_reg,
                                             pct_next, delta_reg};
                        state_reg        <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Register readback.
    always_comb begin
        unique case (paddr[APB_ADDR_W-1:2])
            REG_CONTRACTION: prdata = {{(32-SAMPLE_W){1'b0}}, cthr_reg};
            REG_PRESSURE:    prdata = {{(32-SAMPLE_W){1'b0}}, pthr_reg};
            REG_FULL_SCALE:  prdata = {{(32-FS_W){1'b0}}, fs_reg};
            default:         prdata = '0;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = {{(M_TDATA_W-OUT_BITS){1'b0}}, out_data_reg};

endmodule

>>> design/grbd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gated rolling baseline detector checker
// Port-level properties of the detector, attached by bind.
// ----------------------------------------------------------------------------
module grbd_assertions (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [grbd_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tuser
);
    import grbd_pkg::*;

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // Only one item is in work: the input closes right after an accept.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in work");

    // The percent field never exceeds one hundred.
    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[PCT_LSB +: PCT_W] <= PCT_MAX)
        else $error("percent out of range");

    // After reset the input is open and no result is pending.
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> s_tready && !m_tvalid)
        else $error("wrong handshake state after reset");

endmodule

bind gated_rolling_baseline_detector grbd_assertions u_grbd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> sim/grbd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gated rolling baseline detector checker
// Watches the register port and both streams of the detector. For every
// accepted input beat it predicts the result beat from its own copy of the
// thresholds, windows, running sums and baselines. It compares each accepted
// result beat field by field with the oldest prediction and reports the
// mismatch and pending counts to the test top.
// ----------------------------------------------------------------------------
module grbd_checker
    import grbd_pkg::*;
#(
    parameter int WINDOW_LEN    = 32,
    parameter int CHANNEL_COUNT = 2
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [13:0] sample_mv
    input  logic                  s_tuser,   // [0] channel
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // [14:0] delta_mv, [21:15] pressure_percent, [22] contraction_flag,
    // [23] pressure_flag, [37:24] baseline_mv, rest zero
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  m_tuser,   // [0] channel_out
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    input  logic                  pready,
    output int                    error_count,
    output int                    expected_left
);

    typedef struct {
        logic                       channel;
        logic signed [DELTA_W-1:0]  delta;
        logic [PCT_W-1:0]           percent;
        logic                       contraction;
        logic                       pressure;
        logic signed [SAMPLE_W-1:0] baseline;
    } detector_result_t;

    // Shadow copy of the register file.
    logic signed [SAMPLE_W-1:0] contraction_mv;
    logic signed [SAMPLE_W-1:0] pressure_mv;
    logic [FS_W-1:0]            full_scale_mv;

    // Per-channel averaging state.
    logic signed [SAMPLE_W-1:0] window_mv [CHANNEL_COUNT][WINDOW_LEN];
    int unsigned                fill_index [CHANNEL_COUNT];
    bit                         window_full [CHANNEL_COUNT];
    int                         running_sum [CHANNEL_COUNT];
    logic signed [SAMPLE_W-1:0] channel_baseline [CHANNEL_COUNT];

    detector_result_t awaited_results [$];
    int               mismatches;

    // Computes the result of one sample and advances the channel's window
    // unless the sample reaches the pressure threshold.
    function automatic detector_result_t detect_sample(input logic chan,
                                                       input logic signed [SAMPLE_W-1:0] sample);
        detector_result_t r;
        int ch;
        int s;
        int fs;
        int pct;
        int count;
        ch = int'(chan) % CHANNEL_COUNT;
        s  = sample;
        fs = (full_scale_mv == '0) ? 1 : int'(full_scale_mv);
        r.channel     = chan;
        r.delta       = DELTA_W'(s - int'(channel_baseline[ch]));
        r.contraction = (s >= int'(contraction_mv));
        r.pressure    = (s >= int'(pressure_mv));
        if (s <= 0) begin
            pct = 0;
        end else begin
            pct = (s * 100) / fs;
            if (pct > 100) pct = 100;
        end
        r.percent = PCT_W'(pct);
        if (!r.pressure) begin
            // Once wrapped, the entry being overwritten leaves the sum.
            if (window_full[ch]) running_sum[ch] -= int'(window_mv[ch][fill_index[ch]]);
            window_mv[ch][fill_index[ch]] = sample;
            running_sum[ch] += s;
            fill_index[ch] = (fill_index[ch] + 1) % WINDOW_LEN;
            if (fill_index[ch] == 0) window_full[ch] = 1'b1;
            count = window_full[ch] ? WINDOW_LEN : int'(fill_index[ch]);
            // Signed division truncates toward zero, as the mean must.
            channel_baseline[ch] = SAMPLE_W'(running_sum[ch] / count);
        end
        r.baseline = channel_baseline[ch];
        return r;
    endfunction

    task automatic compare_field(input string field, input int expected, input int actual);
        if (expected != actual) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, field, expected, actual);
            mismatches++;
        end
    endtask

    // Register writes, result beats and input beats, in that order, on every
    // clock edge. A result beat always belongs to an earlier input beat.
    always @(posedge aclk) begin : watch
        detector_result_t awaited;
        if (!aresetn) begin
            contraction_mv = CONTRACTION_RESET;
            pressure_mv    = PRESSURE_RESET;
            full_scale_mv  = FULL_SCALE_RESET;
            for (int c = 0; c < CHANNEL_COUNT; c++) begin
                fill_index[c]       = 0;
                window_full[c]      = 1'b0;
                running_sum[c]      = 0;
                channel_baseline[c] = BASELINE_RESET;
            end
            awaited_results.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[APB_ADDR_W-1:2])
                    REG_CONTRACTION: contraction_mv = pwdata[SAMPLE_W-1:0];
                    REG_PRESSURE:    pressure_mv    = pwdata[SAMPLE_W-1:0];
                    REG_FULL_SCALE:  full_scale_mv  = pwdata[FS_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t ns: result beat expected none, got tdata %h tuser %0d",
                             $time, m_tdata, m_tuser);
                    mismatches++;
                end else begin
                    awaited = awaited_results.pop_front();
                    compare_field("channel_out", int'(awaited.channel), int'(m_tuser));
                    compare_field("delta_mv", int'(awaited.delta),
                                  int'($signed(m_tdata[DELTA_LSB +: DELTA_W])));
                    compare_field("pressure_percent", int'(awaited.percent),
                                  int'(m_tdata[PCT_LSB +: PCT_W]));
                    compare_field("contraction_flag", int'(awaited.contraction),
                                  int'(m_tdata[CFLAG_BIT]));
                    compare_field("pressure_flag", int'(awaited.pressure),
                                  int'(m_tdata[PFLAG_BIT]));
                    compare_field("baseline_mv", int'(awaited.baseline),
                                  int'($signed(m_tdata[BASE_LSB +: SAMPLE_W])));
                    compare_field("tdata padding", 0,
                                  int'(m_tdata[M_TDATA_W-1:OUT_BITS] != '0));
                end
            end
            if (s_tvalid && s_tready) begin
                awaited_results.push_back(detect_sample(s_tuser, s_tdata[SAMPLE_W-1:0]));
            end
        end
        error_count   <= mismatches;
        expected_left <= awaited_results.size();
    end

endmodule

>>> sim/gated_rolling_baseline_detector_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gated rolling baseline detector test
// Drives the detector with a short directed set of samples and then with
// random samples over several threshold and full-scale settings, including
// the extremes. The sender works in bursts and the receiver stalls in modes
// of its own. A separate checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module gated_rolling_baseline_detector_test;
    import grbd_pkg::*;

    localparam int          CLK_HALF     = 6;
    localparam int          RUN_LIMIT_NS = 10_000_000;
    localparam int          SETTINGS_RUN = 8;
    localparam int          PHASE_ITEMS  = 265;
    localparam int          FROZEN_ITEMS = 80;
    localparam int          SAMPLE_MAX   = 2 ** (SAMPLE_W - 1) - 1;
    localparam int          SAMPLE_MIN   = -(2 ** (SAMPLE_W - 1));
    localparam int          FS_MAX       = 2 ** FS_W - 1;
    localparam logic [1:0]  REG_SPARE    = 2'd3;

    typedef enum logic [1:0] {RX_OPEN, RX_CHOPPY, RX_SLOW, RX_BLOCKED} rx_mode_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    int                    error_count;
    int                    expected_left;

    // Settings currently programmed, used to aim samples at the edges.
    int                    contraction_mv = CONTRACTION_RESET;
    int                    pressure_mv    = PRESSURE_RESET;
    int                    full_scale_mv  = FULL_SCALE_RESET;
    int                    burst_left     = 0;
    logic                  sample_channel = 1'b0;

    gated_rolling_baseline_detector u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    grbd_checker u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .error_count   (error_count),
        .expected_left (expected_left)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_HALF) aclk = ~aclk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("gated_rolling_baseline_detector_test: errors");
        $finish;
    end

    // Receiver: switches between open, choppy, slow and blocked stretches.
    initial begin : receiver
        rx_mode_t    mode;
        int unsigned span;
        mode = RX_OPEN;
        span = 0;
        m_tready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (span == 0) begin
                mode = rx_mode_t'($urandom_range(0, 3));
                span = $urandom_range(50, 300);
            end else begin
                span--;
            end
            case (mode)
                RX_OPEN:    m_tready <= 1'b1;
                RX_CHOPPY:  m_tready <= ($urandom_range(0, 3) != 0);
                RX_SLOW:    m_tready <= ($urandom_range(0, 3) == 0);
                RX_BLOCKED: m_tready <= ((span % 32) > 24);
            endcase
        end
    end

    // Register write: a setup phase, an access phase held until pready, then an
    // idle phase; upper pwdata bits carry random noise.
    task automatic write_register(input logic [1:0] index, input int value, input int width);
        int mask;
        mask = (1 << width) - 1;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= ($urandom & ~mask) | (value & mask);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // Presents one input beat, opening a new burst after a random gap first.
    task automatic send_sample(input logic chan, input int sample);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= chan;
        s_tdata  <= {{(S_TDATA_W - SAMPLE_W){1'b0}}, SAMPLE_W'(sample)};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Holds the sender until every expected result beat has been taken.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_left != 0);
    endtask

    // Samples aimed at the thresholds, the full-scale point and the extremes,
    // with most of them in the range that keeps the windows moving.
    function automatic int pick_sample();
        int pick;
        int v;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            v = int'($urandom_range(0, 1400)) - 300;
        end else if (pick < 60) begin
            v = pressure_mv + int'($urandom_range(0, 80)) - 40;
        end else if (pick < 70) begin
            v = contraction_mv + int'($urandom_range(0, 80)) - 40;
        end else if (pick < 78) begin
            v = full_scale_mv + int'($urandom_range(0, 6)) - 3;
        end else if (pick < 94) begin
            v = int'($urandom_range(0, 2 ** SAMPLE_W - 1)) + SAMPLE_MIN;
        end else begin
            case ($urandom_range(0, 4))
                0:       v = SAMPLE_MIN;
                1:       v = SAMPLE_MAX;
                2:       v = 0;
                3:       v = -1;
                default: v = 1;
            endcase
        end
        if (v > SAMPLE_MAX) v = SAMPLE_MAX;
        if (v < SAMPLE_MIN) v = SAMPLE_MIN;
        return v;
    endfunction

    // Programs the thresholds and full scale for one phase of the run.
    task automatic configure_phase(input int phase);
        case (phase)
            1: begin
                // Only the top code reaches pressure, so nearly every sample
                // enters the window.
                contraction_mv = SAMPLE_MIN;
                pressure_mv    = SAMPLE_MIN + (SAMPLE_MAX - SAMPLE_MIN);
                full_scale_mv  = FS_MAX;
            end
            2: begin
                // Every sample reaches pressure and the baselines stay frozen.
                contraction_mv = SAMPLE_MAX;
                pressure_mv    = SAMPLE_MIN;
                full_scale_mv  = 0;
            end
            3: begin
                contraction_mv = int'($urandom_range(0, 2 ** SAMPLE_W - 1)) + SAMPLE_MIN;
                pressure_mv    = $urandom_range(200, 3000);
                full_scale_mv  = 1;
            end
            default: begin
                contraction_mv = ($urandom_range(0, 1) == 0)
                                 ? int'($urandom_range(0, 2 ** SAMPLE_W - 1)) + SAMPLE_MIN
                                 : int'($urandom_range(300, 2500));
                pressure_mv    = $urandom_range(200, 4000);
                full_scale_mv  = $urandom_range(1, FS_MAX);
            end
        endcase
        write_register(REG_CONTRACTION, contraction_mv, SAMPLE_W);
        write_register(REG_PRESSURE, pressure_mv, SAMPLE_W);
        write_register(REG_FULL_SCALE, full_scale_mv, FS_W);
        // An unmapped register must leave the settings alone.
        if (phase == 1) write_register(REG_SPARE, int'($urandom), SAMPLE_W);
    endtask

    initial begin : stimulus
        logic directed_ch [14];
        int   directed_mv [14];
        int   items;
        directed_ch = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
                        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1};
        directed_mv = '{SAMPLE_MAX, SAMPLE_MIN, 0, 499, 500, 999, 1000,
                        3300, 3299, 33, 32, -1, 1, SAMPLE_MIN};
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed beats under the reset settings: range ends, both sides of
        // each threshold, the full-scale point and the one-percent step.
        for (int i = 0; i < 14; i++) send_sample(directed_ch[i], directed_mv[i]);

        for (int phase = 0; phase < SETTINGS_RUN; phase++) begin
            if (phase != 0) begin
                drain_results();
                configure_phase(phase);
            end
            items = (phase == 2) ? FROZEN_ITEMS : PHASE_ITEMS;
            for (int n = 0; n < items; n++) begin
                // Runs on one channel so that windows fill and wrap.
                if ($urandom_range(0, 3) == 0) sample_channel = ~sample_channel;
                send_sample(sample_channel, pick_sample());
            end
        end

        drain_results();
        repeat (40) @(posedge aclk);
        if (error_count == 0) begin
            $display("gated_rolling_baseline_detector_test: clean");
        end else begin
            $display("gated_rolling_baseline_detector_test: errors");
        end
        $finish;
    end

endmodule
